[hdl/bba_pkg.sv]
package bba_pkg;

	localparam int WORD_BITS = 32;
	localparam int WORD_SH = 5;

	localparam logic [31:0] RST_REGION_START = 32'd0;
	localparam logic [31:0] RST_REGION_END = 32'd4194304;
	localparam logic [31:0] RST_BLOCK_BYTES = 32'd4096;

	localparam logic [1:0] REG_REGION_START = 2'd0;
	localparam logic [1:0] REG_REGION_END = 2'd1;
	localparam logic [1:0] REG_BLOCK_BYTES = 2'd2;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE = 2'd1,
		CMD_RESERVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_OOM = 2'd1,
		STAT_IGNORED = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t cmd;
		logic [31:0] free_address;
		logic [10:0] first_block;
		logic [10:0] run_length;
	} req_item_t;

	typedef struct packed {
		status_t status;
		logic [31:0] block_address;
		logic [31:0] free_bytes;
	} rsp_item_t;

	typedef enum logic {
		AOP_MUL = 1'b0,
		AOP_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic start;
		arith_op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] result;
	} arith_sts_t;

	typedef enum logic [1:0] {
		MOP_ZERO = 2'd0,
		MOP_SET = 2'd1,
		MOP_CLEAR = 2'd2
	} map_op_t;

	typedef struct packed {
		logic rd;
		logic wr;
		map_op_t wop;
		logic [31:0] mask;
	} map_req_t;

	typedef struct packed {
		logic any_free;
		logic [4:0] free_bit;
	} map_sts_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_NB_DIV,
		ST_NB_WAIT,
		ST_IDLE,
		ST_AL_RD,
		ST_AL_CHK,
		ST_AL_SET,
		ST_AL_WAIT,
		ST_FR_CHK,
		ST_FR_WAIT,
		ST_FR_RD,
		ST_FR_WR,
		ST_RS_CHK,
		ST_RS_RD,
		ST_RS_WR,
		ST_RS_WAIT,
		ST_FINISH
	} state_t;

endpackage

[hdl/bba_arith.sv]
// Shared shift/add unit: restoring divide (32 steps) or shift-add multiply
// (one multiplier bit per step, stops when the multiplier runs out).
module bba_arith (
	input logic clk,
	input logic arst_n,
	input bba_pkg::arith_req_t req,
	output bba_pkg::arith_sts_t sts
);

	logic busy_q;
	logic done_q;
	bba_pkg::arith_op_t op_q;
	logic [4:0] cnt_q;
	logic [31:0] acc_q;
	logic [31:0] quo_q;
	logic [31:0] opd_q;

	logic [33:0] add_x;
	logic [33:0] add_y;
	logic add_sub;
	logic [33:0] sum;

	always_comb begin
		if (op_q == bba_pkg::AOP_DIV) begin
			add_x = {1'b0, acc_q, quo_q[31]};
			add_y = {2'b00, opd_q};
			add_sub = 1'b1;
		end else begin
			add_x = {2'b00, acc_q};
			add_y = {2'b00, opd_q};
			add_sub = 1'b0;
		end
		sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= bba_pkg::AOP_MUL;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q <= req.op;
			cnt_q <= '0;
			acc_q <= '0;
			if (req.op == bba_pkg::AOP_DIV) begin
				quo_q <= req.a;
				opd_q <= req.b;
			end else begin
				quo_q <= req.b;
				opd_q <= req.a;
			end
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (op_q == bba_pkg::AOP_DIV) begin
					// sign bit clear: partial remainder covers the divisor
					acc_q <= sum[33] ? add_x[31:0] : sum[31:0];
					quo_q <= {quo_q[30:0], ~sum[33]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (quo_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (quo_q[0])
						acc_q <= sum[31:0];
					opd_q <= {opd_q[30:0], 1'b0};
					quo_q <= {1'b0, quo_q[31:1]};
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.result = (op_q == bba_pkg::AOP_DIV) ? quo_q : acc_q;

endmodule

[hdl/bba_map.sv]
// Used-block bitmap, 32 blocks per word, with read-modify-write on the
// last word read and a lowest-free-bit search on that word.
module bba_map #(
	parameter int ROWS = 32,
	parameter int RAW = 5
) (
	input logic clk,
	input bba_pkg::map_req_t req,
	input logic [RAW-1:0] row,
	output bba_pkg::map_sts_t sts
);

	logic [31:0] mem [ROWS];
	logic [31:0] rdata_q;
	logic [31:0] wdata;

	always_comb begin
		case (req.wop)
			bba_pkg::MOP_ZERO: wdata = '0;
			bba_pkg::MOP_SET: wdata = rdata_q | req.mask;
			bba_pkg::MOP_CLEAR: wdata = rdata_q & ~req.mask;
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.rd)
			rdata_q <= mem[row];
		if (req.wr)
			mem[row] <= wdata;
	end

	always_comb begin
		sts.any_free = ~&rdata_q;
		sts.free_bit = '0;
		for (int j = 31; j >= 0; j--) begin
			if (!rdata_q[j])
				sts.free_bit = 5'(j);
		end
	end

endmodule

[hdl/bitmap_block_allocator_unit.sv]
// First-fit fixed-size block allocator. Each request item carries one
// command: allocate (lowest free block, returns its byte address), free
// (releases the block holding free_address, adds block_bytes back), or
// reserve (marks run_length blocks from first_block used); one response item
// per request reports status, the allocated address and the free byte count.
// The bitmap lives in a 32-bit-wide RAM of ceil(NUM_BLOCKS/32) words, and a
// single shift/add unit does all divides and multiplies. One item is
// handled at a time. Allocate reads and checks bitmap words from the lowest
// up, sets the found bit and multiplies the block index by block_bytes;
// free divides the address offset by block_bytes, then reads and clears
// the block's bit; reserve sets its bits one bitmap word at a time and
// multiplies run_length by block_bytes, or, when the run is truncated,
// stops at the managed block count and reports the item ignored. A bad
// command or an out-of-region free is ignored. After reset and after every
// write to a defined register the block clears the bitmap one word per
// cycle and then divides the region size by block_bytes to find the managed
// block count; req_ready stays low meanwhile. A finished response sits in an
// output register, so a new request is taken while the previous response
// waits; a further finished item holds until that register frees up.
module bitmap_block_allocator_unit #(
	parameter int NUM_BLOCKS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bba_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output bba_pkg::rsp_item_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int ROWS = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW = $clog2(NUM_BLOCKS + 1);
	// block index / cursor width: covers the block count and first+run sums
	localparam int CW = (BW > 12) ? BW : 12;

	// config registers
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] bb_q;
	logic cfg_wr;
	logic cfg_hit;

	// sequencer and datapath
	bba_pkg::state_t state_q;
	bba_pkg::state_t state_d;
	bba_pkg::req_item_t item_q;
	bba_pkg::status_t status_q;
	logic [31:0] addr_q;
	logic [31:0] free_q;
	logic [CW-1:0] nb_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] lim_q;
	logic trunc_q;
	logic [RAW-1:0] clr_q;
	logic rsp_valid_q;
	bba_pkg::rsp_item_t rsp_q;

	logic accept;
	logic rsp_free;
	logic clr_last;
	logic [CW-1:0] row_base;
	logic [CW-1:0] next_row;
	logic [CW-1:0] found_idx;
	logic alloc_hit;
	logic fr_out;
	logic q_in;
	logic [CW-1:0] rs_end;
	logic rs_trunc;
	logic [31:0] rs_mask;
	logic [31:0] bit_mask;

	bba_pkg::arith_req_t arith_req;
	bba_pkg::arith_sts_t arith_sts;
	bba_pkg::map_req_t map_req;
	bba_pkg::map_sts_t map_sts;
	logic [RAW-1:0] map_row;

	bba_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.req(arith_req),
		.sts(arith_sts)
	);

	bba_map #(
		.ROWS(ROWS),
		.RAW(RAW)
	) u_map (
		.clk(clk),
		.req(map_req),
		.row(map_row),
		.sts(map_sts)
	);

	// APB: zero-wait, a write lands on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg_hit = cfg_wr && (paddr[3:2] == bba_pkg::REG_REGION_START ||
		paddr[3:2] == bba_pkg::REG_REGION_END || paddr[3:2] == bba_pkg::REG_BLOCK_BYTES);

	always_comb begin
		case (paddr[3:2])
			bba_pkg::REG_REGION_START: prdata = start_q;
			bba_pkg::REG_REGION_END: prdata = end_q;
			bba_pkg::REG_BLOCK_BYTES: prdata = bb_q;
			default: prdata = '0;
		endcase
	end

	assign req_ready = (state_q == bba_pkg::ST_IDLE);
	assign accept = req_valid & req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// helpers for the bitmap walk
	assign clr_last = (clr_q == RAW'(ROWS - 1));
	assign row_base = {cur_q[CW-1:bba_pkg::WORD_SH], {bba_pkg::WORD_SH{1'b0}}};
	assign next_row = row_base + CW'(bba_pkg::WORD_BITS);
	assign found_idx = {cur_q[CW-1:bba_pkg::WORD_SH], map_sts.free_bit};
	// lowest zero bit past the block count means nothing further is free
	assign alloc_hit = map_sts.any_free && (found_idx < nb_q);
	assign fr_out = (bb_q == '0) || (item_q.free_address < start_q) ||
		(item_q.free_address >= end_q);
	assign q_in = (arith_sts.result < 32'(nb_q));
	assign rs_end = CW'(item_q.first_block) + CW'(item_q.run_length);
	assign rs_trunc = (item_q.run_length != '0) && (rs_end > nb_q);
	assign bit_mask = 32'd1 << cur_q[bba_pkg::WORD_SH-1:0];

	always_comb begin
		logic [CW-1:0] gidx;
		gidx = '0;
		rs_mask = '0;
		for (int j = 0; j < bba_pkg::WORD_BITS; j++) begin
			gidx = row_base + CW'(j);
			rs_mask[j] = (gidx >= cur_q) && (gidx < lim_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::ST_CLEAR: begin
				if (clr_last)
					state_d = bba_pkg::ST_NB_DIV;
			end
			bba_pkg::ST_NB_DIV: state_d = bba_pkg::ST_NB_WAIT;
			bba_pkg::ST_NB_WAIT: begin
				if (arith_sts.done)
					state_d = bba_pkg::ST_IDLE;
			end
			bba_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						bba_pkg::CMD_ALLOC: state_d = bba_pkg::ST_AL_RD;
						bba_pkg::CMD_FREE: state_d = bba_pkg::ST_FR_CHK;
						bba_pkg::CMD_RESERVE: state_d = bba_pkg::ST_RS_CHK;
						default: state_d = bba_pkg::ST_FINISH;
					endcase
				end
			end
			bba_pkg::ST_AL_RD: begin
				state_d = (cur_q >= nb_q) ? bba_pkg::ST_FINISH : bba_pkg::ST_AL_CHK;
			end
			bba_pkg::ST_AL_CHK: begin
				if (map_sts.any_free)
					state_d = alloc_hit ? bba_pkg::ST_AL_SET : bba_pkg::ST_FINISH;
				else
					state_d = bba_pkg::ST_AL_RD;
			end
			bba_pkg::ST_AL_SET: state_d = bba_pkg::ST_AL_WAIT;
			bba_pkg::ST_AL_WAIT: begin
				if (arith_sts.done)
					state_d = bba_pkg::ST_FINISH;
			end
			bba_pkg::ST_FR_CHK: begin
				state_d = fr_out ? bba_pkg::ST_FINISH : bba_pkg::ST_FR_WAIT;
			end
			bba_pkg::ST_FR_WAIT: begin
				if (arith_sts.done)
					state_d = q_in ? bba_pkg::ST_FR_RD : bba_pkg::ST_FINISH;
			end
			bba_pkg::ST_FR_RD: state_d = bba_pkg::ST_FR_WR;
			bba_pkg::ST_FR_WR: state_d = bba_pkg::ST_FINISH;
			bba_pkg::ST_RS_CHK: state_d = bba_pkg::ST_RS_RD;
			bba_pkg::ST_RS_RD: begin
				if (cur_q < lim_q)
					state_d = bba_pkg::ST_RS_WR;
				else if (trunc_q)
					state_d = bba_pkg::ST_FINISH;
				else
					state_d = bba_pkg::ST_RS_WAIT;
			end
			bba_pkg::ST_RS_WR: state_d = bba_pkg::ST_RS_RD;
			bba_pkg::ST_RS_WAIT: begin
				if (arith_sts.done)
					state_d = bba_pkg::ST_FINISH;
			end
			bba_pkg::ST_FINISH: begin
				if (rsp_free)
					state_d = bba_pkg::ST_IDLE;
			end
			default: state_d = bba_pkg::ST_CLEAR;
		endcase
		// a write to any defined register restarts the init sequence
		if (cfg_hit)
			state_d = bba_pkg::ST_CLEAR;
	end

	// unit controls
	always_comb begin
		map_req = '0;
		map_req.wop = bba_pkg::MOP_ZERO;
		map_row = cur_q[bba_pkg::WORD_SH +: RAW];
		arith_req = '0;
		arith_req.op = bba_pkg::AOP_MUL;
		case (state_q)
			bba_pkg::ST_CLEAR: begin
				map_req.wr = 1'b1;
				map_req.wop = bba_pkg::MOP_ZERO;
				map_row = clr_q;
			end
			bba_pkg::ST_NB_DIV: begin
				arith_req.start = 1'b1;
				arith_req.op = bba_pkg::AOP_DIV;
				arith_req.a = end_q - start_q;
				arith_req.b = bb_q;
			end
			bba_pkg::ST_AL_RD: begin
				map_req.rd = (cur_q < nb_q);
			end
			bba_pkg::ST_AL_SET: begin
				map_req.wr = 1'b1;
				map_req.wop = bba_pkg::MOP_SET;
				map_req.mask = bit_mask;
				arith_req.start = 1'b1;
				arith_req.op = bba_pkg::AOP_MUL;
				arith_req.a = bb_q;
				arith_req.b = 32'(cur_q);
			end
			bba_pkg::ST_FR_CHK: begin
				arith_req.start = !fr_out;
				arith_req.op = bba_pkg::AOP_DIV;
				arith_req.a = item_q.free_address - start_q;
				arith_req.b = bb_q;
			end
			bba_pkg::ST_FR_RD: begin
				map_req.rd = 1'b1;
			end
			bba_pkg::ST_FR_WR: begin
				map_req.wr = 1'b1;
				map_req.wop = bba_pkg::MOP_CLEAR;
				map_req.mask = bit_mask;
			end
			bba_pkg::ST_RS_RD: begin
				map_req.rd = (cur_q < lim_q);
				arith_req.start = (cur_q >= lim_q) && !trunc_q;
				arith_req.op = bba_pkg::AOP_MUL;
				arith_req.a = bb_q;
				arith_req.b = 32'(item_q.run_length);
			end
			bba_pkg::ST_RS_WR: begin
				map_req.wr = 1'b1;
				map_req.wop = bba_pkg::MOP_SET;
				map_req.mask = rs_mask;
			end
			default: begin
				map_req.rd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_CLEAR;
			start_q <= bba_pkg::RST_REGION_START;
			end_q <= bba_pkg::RST_REGION_END;
			bb_q <= bba_pkg::RST_BLOCK_BYTES;
			free_q <= bba_pkg::RST_REGION_END - bba_pkg::RST_REGION_START;
			nb_q <= '0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			case (state_q)
				bba_pkg::ST_CLEAR: begin
					// row counter sits at zero whenever the clear pass is not running
					clr_q <= (cfg_hit || clr_last) ? '0 : clr_q + RAW'(1);
					free_q <= end_q - start_q;
				end
				bba_pkg::ST_NB_WAIT: begin
					if (arith_sts.done) begin
						if (bb_q == '0)
							nb_q <= '0;
						else if (arith_sts.result >= 32'(NUM_BLOCKS))
							nb_q <= CW'(NUM_BLOCKS);
						else
							nb_q <= arith_sts.result[CW-1:0];
					end
				end
				bba_pkg::ST_IDLE: begin
					if (accept) begin
						item_q <= req;
						cur_q <= '0;
						addr_q <= '0;
						case (req.cmd)
							bba_pkg::CMD_ALLOC: status_q <= bba_pkg::STAT_DONE;
							bba_pkg::CMD_FREE: status_q <= bba_pkg::STAT_DONE;
							bba_pkg::CMD_RESERVE: status_q <= bba_pkg::STAT_DONE;
							default: status_q <= bba_pkg::STAT_IGNORED;
						endcase
					end
				end
				bba_pkg::ST_AL_RD: begin
					if (cur_q >= nb_q)
						status_q <= bba_pkg::STAT_OOM;
				end
				bba_pkg::ST_AL_CHK: begin
					if (!map_sts.any_free)
						cur_q <= next_row;
					else if (alloc_hit)
						cur_q <= found_idx;
					else
						status_q <= bba_pkg::STAT_OOM;
				end
				bba_pkg::ST_AL_WAIT: begin
					if (arith_sts.done) begin
						addr_q <= start_q + arith_sts.result;
						free_q <= free_q - bb_q;
					end
				end
				bba_pkg::ST_FR_CHK: begin
					if (fr_out)
						status_q <= bba_pkg::STAT_IGNORED;
				end
				bba_pkg::ST_FR_WAIT: begin
					// count goes up even when the block lies past the map
					if (arith_sts.done) begin
						free_q <= free_q + bb_q;
						cur_q <= arith_sts.result[CW-1:0];
					end
				end
				bba_pkg::ST_RS_CHK: begin
					cur_q <= CW'(item_q.first_block);
					lim_q <= rs_trunc ? nb_q : rs_end;
					trunc_q <= rs_trunc;
				end
				bba_pkg::ST_RS_RD: begin
					if (cur_q >= lim_q && trunc_q)
						status_q <= bba_pkg::STAT_IGNORED;
				end
				bba_pkg::ST_RS_WR: begin
					cur_q <= next_row;
				end
				bba_pkg::ST_RS_WAIT: begin
					if (arith_sts.done)
						free_q <= free_q - arith_sts.result;
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase

			// response register
			if (state_q == bba_pkg::ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
				rsp_q.status <= status_q;
				rsp_q.block_address <= addr_q;
				rsp_q.free_bytes <= free_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				case (paddr[3:2])
					bba_pkg::REG_REGION_START: start_q <= pwdata;
					bba_pkg::REG_REGION_END: end_q <= pwdata;
					bba_pkg::REG_BLOCK_BYTES: bb_q <= pwdata;
					default: start_q <= start_q;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// a write to a defined register always blocks new items until re-init is over
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !req_ready)
		else $error("item taken right after register write");

	// only a successful allocate carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bba_pkg::STAT_DONE |-> rsp.block_address == '0)
		else $error("address on failed or ignored item");

	// managed block count never exceeds the bitmap
	a_nb_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bba_pkg::ST_IDLE |-> nb_q <= CW'(NUM_BLOCKS))
		else $error("block count beyond bitmap size");
`endif

endmodule
